[rtl/qsp_pkg.sv]
// Shared types, constants and saturating fixed-point helpers for the
// quintic segment point evaluator. No dependencies.
package qsp_pkg;

  typedef logic signed [63:0] q64_t;

  localparam q64_t Q64_MAX = {1'b0, {63{1'b1}}};
  localparam q64_t Q64_MIN = {1'b1, {63{1'b0}}};

  function automatic logic [63:0] qsp_mag(q64_t x);
    qsp_mag = x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic q64_t qsp_from_mag(logic [63:0] m, logic neg, logic over);
    if (neg) begin
      qsp_from_mag = (over || m[63]) ? Q64_MIN : q64_t'(~m + 64'd1);
    end else begin
      qsp_from_mag = (over || m[63]) ? Q64_MAX : q64_t'(m);
    end
  endfunction

  function automatic q64_t qsp_sadd(q64_t a, q64_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      qsp_sadd = s[64] ? Q64_MIN : Q64_MAX;
    end else begin
      qsp_sadd = s[63:0];
    end
  endfunction

  function automatic q64_t qsp_ssub(q64_t a, q64_t b);
    q64_t nb;
    nb = (b == Q64_MIN) ? Q64_MAX : -b;
    qsp_ssub = qsp_sadd(a, nb);
  endfunction

  function automatic logic signed [31:0] qsp_sat32(q64_t v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      qsp_sat32 = 32'sh7FFF_FFFF;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      qsp_sat32 = 32'sh8000_0000;
    end else begin
      qsp_sat32 = v[31:0];
    end
  endfunction

endpackage

[rtl/qsp_dly.sv]
// Fixed-length delay line used to align operands between pipeline stages.
// No dependencies.
module qsp_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_q [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

[rtl/qsp_mul.sv]
// Four-stage fixed-point multiplier: magnitudes, 32x32 partial products,
// 128-bit sum, then round to nearest and saturate. Uses qsp_pkg.
module qsp_mul #(
  parameter int FRAC_BITS = 24
) (
  input  logic          clk_i,
  input  qsp_pkg::q64_t a_i,
  input  qsp_pkg::q64_t b_i,
  output qsp_pkg::q64_t p_o
);
  import qsp_pkg::*;

  logic [63:0]  ax_q, ay_q;
  logic         n1_q, n2_q, n3_q;
  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [127:0] full_q;
  q64_t         p_q;

  logic [127:0] rnd;
  logic [63:0]  rl;
  logic         over;

  always_ff @(posedge clk_i) begin
    ax_q  <= qsp_mag(a_i);
    ay_q  <= qsp_mag(b_i);
    n1_q  <= a_i[63] ^ b_i[63];
    p00_q <= {32'd0, ax_q[31:0]} * {32'd0, ay_q[31:0]};
    p01_q <= {32'd0, ax_q[31:0]} * {32'd0, ay_q[63:32]};
    p10_q <= {32'd0, ax_q[63:32]} * {32'd0, ay_q[31:0]};
    p11_q <= {32'd0, ax_q[63:32]} * {32'd0, ay_q[63:32]};
    n2_q  <= n1_q;
    full_q <= {64'd0, p00_q} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
              + {p11_q, 64'd0};
    n3_q  <= n2_q;
    p_q   <= qsp_from_mag(rl, n3_q, over);
  end

  assign rnd  = full_q + (128'd1 << (FRAC_BITS - 1));
  assign rl   = rnd[FRAC_BITS +: 64];
  assign over = |rnd[127:FRAC_BITS+64];
  assign p_o  = p_q;

endmodule

[rtl/qsp_div.sv]
// Pipelined restoring divider of a fixed-point value by a 32-bit unsigned
// divisor, one quotient bit per stage, rounded and saturated. Uses qsp_pkg.
module qsp_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic          clk_i,
  input  qsp_pkg::q64_t x_i,
  input  logic [31:0]   y_i,
  output qsp_pkg::q64_t q_o
);
  import qsp_pkg::*;

  localparam int DW = 64 + FRAC_BITS;

  logic [31:0]   rem_q [0:DW];
  logic [DW-1:0] n_q   [0:DW];
  logic [31:0]   y_q   [0:DW];
  logic          neg_q [0:DW];
  logic          yz_q  [0:DW];
  q64_t          q_q;

  logic          over;
  logic          rnd;
  logic [64:0]   ql;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    n_q[0]   <= {qsp_mag(x_i), {FRAC_BITS{1'b0}}};
    y_q[0]   <= y_i;
    neg_q[0] <= x_i[63];
    yz_q[0]  <= (y_i == '0);
  end

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [32:0] cur, dif;
    logic        ge;
    assign cur = {rem_q[k], n_q[k][DW-1]};
    assign ge  = (cur >= {1'b0, y_q[k]});
    assign dif = cur - {1'b0, y_q[k]};
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? dif[31:0] : cur[31:0];
      n_q[k+1]   <= {n_q[k][DW-2:0], ge};
      y_q[k+1]   <= y_q[k];
      neg_q[k+1] <= neg_q[k];
      yz_q[k+1]  <= yz_q[k];
    end
  end

  assign over = |n_q[DW][DW-1:64];
  assign rnd  = ({rem_q[DW], 1'b0} >= {1'b0, y_q[DW]});
  assign ql   = {1'b0, n_q[DW][63:0]} + {64'd0, rnd};

  always_ff @(posedge clk_i) begin
    q_q <= yz_q[DW] ? '0 : qsp_from_mag(ql[63:0], neg_q[DW], over | ql[64]);
  end

  assign q_o = q_q;

endmodule

[rtl/quintic_segment_point_evaluator.sv]
// Top level of the quintic segment point evaluator: input register, three
// dividers, a chain of multiplier stages and the saturating output stage.
// Uses qsp_pkg, qsp_mul, qsp_div and qsp_dly.
//
// The block takes one word per clock cycle and never raises busy. Each word
// yields exactly one result on done_o, in acceptance order. The result path
// runs through two dividers in series, which deliver one quotient bit per
// stage, and through the four-stage multiplier after the second one.
// The receiver cannot stall, so each result must be taken as it appears.
module quintic_segment_point_evaluator #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] start_pos_i,
  input  logic signed [31:0] via_pos_i,
  input  logic signed [31:0] next_pos_i,
  input  logic signed [31:0] start_vel_i,
  input  logic [31:0]        seg_time_i,
  input  logic [31:0]        span_time_i,
  input  logic [31:0]        sample_time_i,
  output logic               done_o,
  output logic signed [31:0] pos_out_o,
  output logic signed [31:0] vel_out_o,
  output logic               singular_o
);
  import qsp_pkg::*;

  localparam int LM  = 4;
  localparam int LD  = 66 + FRAC_BITS;
  localparam int T_H = 2 * LD + 1 + LM;
  localparam int LAT = T_H + 2;

  localparam q64_t QONE = 64'sd1 <<< FRAC_BITS;
  localparam q64_t K3   = 64'sd3 <<< FRAC_BITS;
  localparam q64_t K4   = 64'sd4 <<< FRAC_BITS;
  localparam q64_t K6   = 64'sd6 <<< FRAC_BITS;
  localparam q64_t K7   = 64'sd7 <<< FRAC_BITS;
  localparam q64_t K10  = 64'sd10 <<< FRAC_BITS;
  localparam q64_t K12  = 64'sd12 <<< FRAC_BITS;
  localparam q64_t K15  = 64'sd15 <<< FRAC_BITS;
  localparam q64_t K28  = 64'sd28 <<< FRAC_BITS;
  localparam q64_t K30  = 64'sd30 <<< FRAC_BITS;

  logic               in_vld_q;
  logic signed [31:0] p0_q, p1_q, p2_q, v0_q;
  logic [31:0]        seg_q, span_q, t_q;
  logic [T_H:1]       vld_q;

  logic signed [32:0] d1, d2, diff;
  logic               like, vsel, tsz, sing;
  q64_t               v0x, tx, segx, diffx;

  q64_t               v1raw_a, s_a, m_v0t_m, m_v0T_m, m_v0t_a, m_v0T_a;
  logic [97:0]        pk_a;
  logic signed [31:0] p0_a, v0_a;
  logic signed [32:0] d1_a;
  logic               vsel_a;
  q64_t               v1_a;

  q64_t               w_b_q, dres_b_q, sm1_b_q, posb_b_q, s_b_q;
  logic [31:0]        seg_b;

  q64_t               s2_c, sm1sq_c, k15s_c, k7s_c, k28s_c, wt_c, s_c;
  logic [191:0]       kd_d;
  q64_t               s3_d, k6s2_d, k3s2_d, k15s2_d, ga_d;
  q64_t               poly1_e_q, poly2_e_q, poly3_e_q, s3_e_q, ga_e_q, s2_e;

  q64_t               h1_f, h2_f, g1_f, g2_f;
  logic [255:0]       hg_g;
  logic [127:0]       dw_g;
  q64_t               wt_g, dt_g;
  q64_t               a_h, b_h, c_h, e_h, posb_h;
  logic [33:0]        pk_h;

  logic               done_q, sing_q;
  logic signed [31:0] pos_q, vel_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      vld_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
      vld_q    <= {vld_q[T_H-1:1], in_vld_q};
      done_q   <= vld_q[T_H];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      p0_q   <= start_pos_i;
      p1_q   <= via_pos_i;
      p2_q   <= next_pos_i;
      v0_q   <= start_vel_i;
      seg_q  <= seg_time_i;
      span_q <= span_time_i;
      t_q    <= sample_time_i;
    end
  end

  assign d1    = {p1_q[31], p1_q} - {p0_q[31], p0_q};
  assign d2    = {p2_q[31], p2_q} - {p1_q[31], p1_q};
  assign diff  = {p2_q[31], p2_q} - {p0_q[31], p0_q};
  assign like  = (!d1[32] && (d1 != '0) && !d2[32] && (d2 != '0)) || (d1[32] && d2[32]);
  assign vsel  = like && (span_q != '0);
  assign tsz   = (seg_q == '0);
  assign sing  = tsz || (span_q == '0);
  assign v0x   = {{32{v0_q[31]}}, v0_q};
  assign tx    = {32'd0, t_q};
  assign segx  = {32'd0, seg_q};
  assign diffx = {{31{diff[32]}}, diff};

  qsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_v1 (.clk_i, .x_i(diffx), .y_i(span_q), .q_o(v1raw_a));
  qsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_s  (.clk_i, .x_i(tx), .y_i(seg_q), .q_o(s_a));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_v0t (.clk_i, .a_i(v0x), .b_i(tx), .p_o(m_v0t_m));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_v0T (.clk_i, .a_i(v0x), .b_i(segx), .p_o(m_v0T_m));

  qsp_dly #(.WIDTH(128), .DEPTH(LD - LM)) u_dly_m0 (
    .clk_i, .d_i({m_v0t_m, m_v0T_m}), .q_o({m_v0t_a, m_v0T_a}));
  qsp_dly #(.WIDTH(98), .DEPTH(LD)) u_dly_a (
    .clk_i, .d_i({p0_q, v0_q, d1, vsel}), .q_o(pk_a));
  qsp_dly #(.WIDTH(32), .DEPTH(LD + 1)) u_dly_seg (.clk_i, .d_i(seg_q), .q_o(seg_b));
  qsp_dly #(.WIDTH(34), .DEPTH(T_H)) u_dly_h (
    .clk_i, .d_i({v0_q, tsz, sing}), .q_o(pk_h));

  assign p0_a   = pk_a[97:66];
  assign v0_a   = pk_a[65:34];
  assign d1_a   = pk_a[33:1];
  assign vsel_a = pk_a[0];
  assign v1_a   = vsel_a ? v1raw_a : '0;

  always_ff @(posedge clk_i) begin
    w_b_q    <= qsp_ssub(v1_a, {{32{v0_a[31]}}, v0_a});
    dres_b_q <= qsp_ssub({{31{d1_a[32]}}, d1_a}, m_v0T_a);
    sm1_b_q  <= qsp_ssub(s_a, QONE);
    posb_b_q <= qsp_sadd({{32{p0_a[31]}}, p0_a}, m_v0t_a);
    s_b_q    <= s_a;
  end

  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_s2   (.clk_i, .a_i(s_b_q), .b_i(s_b_q), .p_o(s2_c));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_sm1  (.clk_i, .a_i(sm1_b_q), .b_i(sm1_b_q),
                                               .p_o(sm1sq_c));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k15s (.clk_i, .a_i(s_b_q), .b_i(K15), .p_o(k15s_c));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k7s  (.clk_i, .a_i(s_b_q), .b_i(K7), .p_o(k7s_c));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k28s (.clk_i, .a_i(s_b_q), .b_i(K28), .p_o(k28s_c));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_wt   (.clk_i, .a_i(w_b_q), .b_i({32'd0, seg_b}),
                                               .p_o(wt_c));
  qsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_dt   (.clk_i, .x_i(dres_b_q), .y_i(seg_b), .q_o(dt_g));

  qsp_dly #(.WIDTH(64), .DEPTH(LM)) u_dly_s (.clk_i, .d_i(s_b_q), .q_o(s_c));

  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_s3    (.clk_i, .a_i(s2_c), .b_i(s_c), .p_o(s3_d));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k6s2  (.clk_i, .a_i(s2_c), .b_i(K6), .p_o(k6s2_d));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k3s2  (.clk_i, .a_i(s2_c), .b_i(K3), .p_o(k3s2_d));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k15s2 (.clk_i, .a_i(s2_c), .b_i(K15), .p_o(k15s2_d));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ga    (.clk_i, .a_i(s2_c), .b_i(sm1sq_c), .p_o(ga_d));

  qsp_dly #(.WIDTH(192), .DEPTH(LM)) u_dly_k (
    .clk_i, .d_i({k15s_c, k7s_c, k28s_c}), .q_o(kd_d));
  qsp_dly #(.WIDTH(64), .DEPTH(LM + 1)) u_dly_s2 (.clk_i, .d_i(s2_c), .q_o(s2_e));

  always_ff @(posedge clk_i) begin
    poly1_e_q <= qsp_sadd(qsp_ssub(k6s2_d, q64_t'(kd_d[191:128])), K10);
    poly2_e_q <= qsp_ssub(qsp_ssub(q64_t'(kd_d[127:64]), k3s2_d), K4);
    poly3_e_q <= qsp_ssub(qsp_ssub(q64_t'(kd_d[63:0]), k15s2_d), K12);
    s3_e_q    <= s3_d;
    ga_e_q    <= ga_d;
  end

  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_h1 (.clk_i, .a_i(s3_e_q), .b_i(poly1_e_q), .p_o(h1_f));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_h2 (.clk_i, .a_i(s3_e_q), .b_i(poly2_e_q), .p_o(h2_f));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_g1 (.clk_i, .a_i(ga_e_q), .b_i(K30), .p_o(g1_f));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_g2 (.clk_i, .a_i(s2_e), .b_i(poly3_e_q), .p_o(g2_f));

  qsp_dly #(.WIDTH(256), .DEPTH(LD - 3 * LM - 1)) u_dly_hg (
    .clk_i, .d_i({h1_f, h2_f, g1_f, g2_f}), .q_o(hg_g));
  qsp_dly #(.WIDTH(128), .DEPTH(LD)) u_dly_dw (
    .clk_i, .d_i({dres_b_q, w_b_q}), .q_o(dw_g));
  qsp_dly #(.WIDTH(64), .DEPTH(LD - LM)) u_dly_wt (.clk_i, .d_i(wt_c), .q_o(wt_g));
  qsp_dly #(.WIDTH(64), .DEPTH(LD + LM)) u_dly_posb (.clk_i, .d_i(posb_b_q), .q_o(posb_h));

  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (
    .clk_i, .a_i(q64_t'(dw_g[127:64])), .b_i(q64_t'(hg_g[255:192])), .p_o(a_h));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b (
    .clk_i, .a_i(wt_g), .b_i(q64_t'(hg_g[191:128])), .p_o(b_h));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_c (
    .clk_i, .a_i(dt_g), .b_i(q64_t'(hg_g[127:64])), .p_o(c_h));
  qsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_e (
    .clk_i, .a_i(q64_t'(dw_g[63:0])), .b_i(q64_t'(hg_g[63:0])), .p_o(e_h));

  always_ff @(posedge clk_i) begin
    sing_q <= pk_h[0];
    if (pk_h[1]) begin
      pos_q <= qsp_sat32(posb_h);
      vel_q <= pk_h[33:2];
    end else begin
      pos_q <= qsp_sat32(qsp_sadd(qsp_sadd(posb_h, a_h), b_h));
      vel_q <= qsp_sat32(qsp_sadd(qsp_sadd({{32{pk_h[33]}}, pk_h[33:2]}, c_h), e_h));
    end
  end

  assign done_o     = done_q;
  assign pos_out_o  = pos_q;
  assign vel_out_o  = vel_q;
  assign singular_o = sing_q;

  a_done_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result word without an accepted input word");

  a_zero_seg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(seg_time_i == '0, LAT))
      |-> (singular_o && (vel_out_o == $past(start_vel_i, LAT))))
    else $error("zero segment time word not passed through");

  a_zero_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(span_time_i == '0, LAT)) |-> singular_o)
    else $error("zero span time word not flagged");

  a_regular : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past((seg_time_i != '0) && (span_time_i != '0), LAT)) |-> !singular_o)
    else $error("regular word flagged singular");

endmodule
